### sv/tfmt_pkg.sv
// ---------------------------------------------------------------------------
// tfmt_pkg: shared definitions for the magnitude threshold core
// Widths, register offsets, controller states and the magnitude function.
// ---------------------------------------------------------------------------
package tfmt_pkg;

  // Coefficient and magnitude widths
  localparam int COEFF_W = 32;
  localparam int MAG_W   = COEFF_W - 1;

  // Coefficient store depth and derived widths
  localparam int MAX_COEFFS = 4096;
  localparam int ADDR_W     = $clog2(MAX_COEFFS);
  localparam int CNT_W      = $clog2(MAX_COEFFS + 1);

  // Ratio register and the shift-subtract divider
  localparam int RATIO_W   = 16;
  localparam int DIV_CW    = $clog2(CNT_W + 1);
  localparam int BIT_CW    = $clog2(MAG_W);

  // Configuration port
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam logic REG_RATIO = 1'b0;
  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(1);

  // Word kinds on the input channel
  localparam logic KIND_GATHER = 1'b0;
  localparam logic KIND_APPLY  = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SWEEP,
    ST_DECIDE
  } state_t;

  // Magnitude of a signed coefficient; the most negative value saturates.
  function automatic logic [MAG_W-1:0] magnitude(input logic [COEFF_W-1:0] w);
    logic [COEFF_W-1:0] neg;
    neg = (~w) + COEFF_W'(1);
    if (!w[COEFF_W-1]) begin
      magnitude = w[MAG_W-1:0];
    end else if (neg[COEFF_W-1]) begin
      magnitude = {MAG_W{1'b1}};
    end else begin
      magnitude = neg[MAG_W-1:0];
    end
  endfunction

endpackage

### sv/top_fraction_magnitude_threshold_core.sv
// Apply words: one per cycle unless stalled; result registered next cycle.
// Gather words: one per cycle while idle, stored into the magnitude memory.
// After the last gather word the threshold search runs a 13-step divider,
// then one full read sweep of the stored words per magnitude bit.
// Synchronous active-low reset clears the state, count, threshold, flags and
// output valid; the memory and the working registers are not cleared.
// ---------------------------------------------------------------------------
// top_fraction_magnitude_threshold_core
// Keeps roughly the largest 1/ratio of a block of coefficients by magnitude
// and zeroes the rest, using a bitwise radix selection over a stored block.
// ---------------------------------------------------------------------------
module top_fraction_magnitude_threshold_core
  import tfmt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Input stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [COEFF_W-1:0] in_tdata,   // [31:0] coefficient
  input  logic               in_tuser,   // [0] kind
  input  logic               in_tlast,
  // Result stream
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [COEFF_W-1:0] out_tdata,  // [31:0] coefficient_out
  output logic               out_tuser,  // [0] capacity_exceeded
  output logic               out_tlast,
  // Configuration port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [CFG_AW-1:0]  cfg_paddr,
  input  logic [CFG_DW-1:0]  cfg_pwdata,
  output logic [CFG_DW-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  // Magnitude memory
  logic [MAG_W-1:0] mem [MAX_COEFFS];
  logic [MAG_W-1:0] mem_q_r;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;

  // Control and block state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [MAG_W-1:0] thresh_r, thresh_nxt;
  logic             ovf_r, ovf_nxt;
  logic             done_r, done_nxt;
  logic [RATIO_W-1:0] ratio_r;

  // Divider
  logic [DIV_CW-1:0]  div_cnt_r, div_cnt_nxt;
  logic [RATIO_W:0]   div_rem_r, div_rem_nxt;
  logic [CNT_W-1:0]   div_q_r, div_q_nxt;
  logic [RATIO_W:0]   div_trial;

  // Selection
  logic [BIT_CW-1:0] bit_r, bit_nxt;
  logic [MAG_W-1:0]  onehot_r, onehot_nxt;
  logic [MAG_W-1:0]  himask_r, himask_nxt;
  logic [MAG_W-1:0]  result_r, result_nxt;
  logic [CNT_W-1:0]  rank_r, rank_nxt;
  logic [CNT_W-1:0]  hits_r, hits_nxt;
  logic [CNT_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [MAG_W-1:0]  cand;

  // Output register
  logic               out_vld_r, out_vld_nxt;
  logic [COEFF_W-1:0] out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  // Input side helpers
  logic             in_acc;
  logic [MAG_W-1:0] in_mag;
  logic [CNT_W-1:0] eff_count;
  logic [CNT_W-1:0] new_count;

  // Configuration register and read-back
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= RATIO_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[CFG_AW-1] == REG_RATIO) begin
      ratio_r <= cfg_pwdata[RATIO_W-1:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[CFG_AW-1] == REG_RATIO) ?
                      {{(CFG_DW-RATIO_W){1'b0}}, ratio_r} : '0;

  // Handshake and stream outputs
  assign in_tready  = (state_r == ST_IDLE) && (!out_vld_r || out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign in_mag     = magnitude(in_tdata);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  // A new block restarts the count once the previous one is complete.
  assign eff_count = done_r ? '0 : count_r;
  assign new_count = eff_count + CNT_W'(1);

  assign div_trial = {div_rem_r[RATIO_W-1:0], div_q_r[CNT_W-1]};
  assign cand      = result_r | onehot_r;
  assign mem_raddr = rd_addr_r[ADDR_W-1:0];
  assign mem_waddr = eff_count[ADDR_W-1:0];

  // Memory: one write port for gathering, one registered read port for sweeps
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_mag;
    end
  end

  always_ff @(posedge clk) begin
    mem_q_r <= mem[mem_raddr];
  end

  // Next state and datapath
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    thresh_nxt   = thresh_r;
    ovf_nxt      = ovf_r;
    done_nxt     = done_r;
    div_cnt_nxt  = div_cnt_r;
    div_rem_nxt  = div_rem_r;
    div_q_nxt    = div_q_r;
    bit_nxt      = bit_r;
    onehot_nxt   = onehot_r;
    himask_nxt   = himask_r;
    result_nxt   = result_r;
    rank_nxt     = rank_r;
    hits_nxt     = hits_r;
    rd_addr_nxt  = rd_addr_r;
    rd_vld_nxt   = 1'b0;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    out_ovf_nxt  = out_ovf_r;
    mem_we       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser == KIND_APPLY) begin
          // Apply word: pass or zero against the current threshold
          out_vld_nxt  = 1'b1;
          out_data_nxt = (in_mag < thresh_r) ? '0 : in_tdata;
          out_last_nxt = in_tlast;
          out_ovf_nxt  = ovf_r;
        end else if (in_acc) begin
          // Gather word: store the magnitude or flag the overflow
          done_nxt = 1'b0;
          if (eff_count < CNT_W'(MAX_COEFFS)) begin
            mem_we    = 1'b1;
            count_nxt = new_count;
          end else begin
            count_nxt = eff_count;
          end
          ovf_nxt = (done_r ? 1'b0 : ovf_r) ||
                    (eff_count >= CNT_W'(MAX_COEFFS));
          if (in_tlast) begin
            if (ratio_r <= RATIO_W'(1) || count_nxt == '0) begin
              thresh_nxt = '0;
              done_nxt   = 1'b1;
            end else begin
              div_cnt_nxt = '0;
              div_rem_nxt = '0;
              div_q_nxt   = count_nxt;
              state_nxt   = ST_DIV;
            end
          end
        end
      end

      ST_DIV: begin
        // One quotient bit per cycle: k = count / ratio
        if (div_trial >= {1'b0, ratio_r}) begin
          div_rem_nxt = div_trial - {1'b0, ratio_r};
          div_q_nxt   = {div_q_r[CNT_W-2:0], 1'b1};
        end else begin
          div_rem_nxt = div_trial;
          div_q_nxt   = {div_q_r[CNT_W-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + DIV_CW'(1);
        if (div_cnt_r == DIV_CW'(CNT_W - 1)) begin
          rank_nxt    = div_q_nxt;
          result_nxt  = '0;
          bit_nxt     = BIT_CW'(MAG_W - 1);
          onehot_nxt  = {1'b1, {(MAG_W-1){1'b0}}};
          himask_nxt  = {1'b1, {(MAG_W-1){1'b0}}};
          hits_nxt    = '0;
          rd_addr_nxt = '0;
          state_nxt   = ST_SWEEP;
        end
      end

      ST_SWEEP: begin
        // Count stored magnitudes whose upper bits match the candidate
        if (rd_addr_r < count_r) begin
          rd_addr_nxt = rd_addr_r + CNT_W'(1);
          rd_vld_nxt  = 1'b1;
        end
        if (rd_vld_r && ((mem_q_r ^ cand) & himask_r) == '0) begin
          hits_nxt = hits_r + CNT_W'(1);
        end
        if (rd_addr_r == count_r && !rd_vld_r) begin
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        // Keep the bit if enough entries lie at or above the candidate
        if (hits_r > rank_r) begin
          result_nxt = cand;
        end else begin
          rank_nxt = rank_r - hits_r;
        end
        if (bit_r == '0) begin
          thresh_nxt = result_nxt;
          done_nxt   = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          bit_nxt     = bit_r - BIT_CW'(1);
          onehot_nxt  = onehot_r >> 1;
          himask_nxt  = himask_r | (himask_r >> 1);
          hits_nxt    = '0;
          rd_addr_nxt = '0;
          state_nxt   = ST_SWEEP;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      thresh_r  <= '0;
      ovf_r     <= 1'b0;
      done_r    <= 1'b0;
      out_vld_r <= 1'b0;
      rd_vld_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      thresh_r  <= thresh_nxt;
      ovf_r     <= ovf_nxt;
      done_r    <= done_nxt;
      out_vld_r <= out_vld_nxt;
      rd_vld_r  <= rd_vld_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    div_cnt_r  <= div_cnt_nxt;
    div_rem_r  <= div_rem_nxt;
    div_q_r    <= div_q_nxt;
    bit_r      <= bit_nxt;
    onehot_r   <= onehot_nxt;
    himask_r   <= himask_nxt;
    result_r   <= result_nxt;
    rank_r     <= rank_nxt;
    hits_r     <= hits_nxt;
    rd_addr_r  <= rd_addr_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

`ifndef SYNTH
  // The block never holds more magnitudes than the memory has entries.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_COEFFS))
    else $error("gathered count exceeds store depth");

  // The sweep never reads beyond the gathered entries.
  a_sweep_addr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SWEEP |-> rd_addr_r <= count_r)
    else $error("sweep address beyond gathered count");

  // The remaining rank always points inside the block during selection.
  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP || state_r == ST_DECIDE) |-> rank_r < count_r)
    else $error("selection rank outside block");

  // A finished threshold search always ends in the idle state.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> state_r == ST_IDLE)
    else $error("block marked complete while busy");
`endif

endmodule
